### hw/rtl/kmc_pkg.sv
// ----------------------------------------------------------------------------
// kmc_pkg: shared constants and types of the k-means clustering block
// Widths, register indexes and status codes used by every file.
// ----------------------------------------------------------------------------
package kmc_pkg;
	localparam int MAX_POINTS   = 64;
	localparam int MAX_CLUSTERS = 8;
	localparam int COORD_WIDTH  = 16;
	localparam int PIDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int CID_W  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
	localparam int K_W    = $clog2(MAX_CLUSTERS + 1);
	localparam int DIFF_W = COORD_WIDTH + 1;
	localparam int SQ_W   = 2 * DIFF_W;
	localparam int DIST_W = SQ_W + 2;
	localparam int SUM_W  = COORD_WIDTH + PIDX_W;
	localparam int CFG_W  = 8;
	localparam int CIDX_W = 2;

	localparam logic [CIDX_W-1:0] REG_NUM_CLUSTERS = 2'd0;
	localparam logic [CIDX_W-1:0] REG_SEED_START   = 2'd1;
	localparam logic [CIDX_W-1:0] REG_MAX_ITER     = 2'd2;

	localparam logic [1:0] ST_CONVERGED = 2'd0;
	localparam logic [1:0] ST_LIMIT     = 2'd1;
	localparam logic [1:0] ST_TOO_FEW   = 2'd2;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;
	typedef struct packed {
		logic start;
		logic last;
	} div_ctl_t;
endpackage

### hw/rtl/kmc_divider.sv
// ----------------------------------------------------------------------------
// kmc_divider: restoring divider for centroid means
// Signed sum over unsigned count, truncating toward zero, one bit a cycle.
// ----------------------------------------------------------------------------
module kmc_divider import kmc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [SUM_W-1:0] dividend,
	input  logic [CNT_W-1:0]        divisor,
	output logic                    done,
	output coord_t                  quotient
);
	localparam int STEP_W = $clog2(SUM_W + 1);

	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  den_q;
	logic              neg_q;
	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W:0]    trial;
	logic [SUM_W-1:0]  mag;
	logic [SUM_W-1:0]  res;

	assign mag   = dividend[SUM_W-1] ? SUM_W'(-dividend) : dividend;
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign res   = neg_q ? SUM_W'(-quo_q) : quo_q;
	assign quotient = coord_t'(res[COORD_WIDTH-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			step_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(SUM_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// The remainder always stays below the divisor, so it fits the count width.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= mag;
			rem_q <= '0;
			den_q <= (divisor == '0) ? CNT_W'(1) : divisor;
			neg_q <= dividend[SUM_W-1];
		end else if (busy_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= CNT_W'(trial - {1'b0, den_q});
				quo_q <= {quo_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[CNT_W-1:0];
				quo_q <= {quo_q[SUM_W-2:0], 1'b0};
			end
		end
	end
endmodule

### hw/rtl/kmeans_point_clustering.sv
// ----------------------------------------------------------------------------
// kmeans_point_clustering: Lloyd k-means over a stored set of 3D points
// Loads points, clusters them and emits one label per point, or one too-few status result.
// ----------------------------------------------------------------------------
// Channel  | Ports                                       | Handshake
// ---------+---------------------------------------------+------------------
// input    | coord_x, coord_y, coord_z, final_point      | start && !busy
// result   | point_index, cluster_id, run_status,        | out_valid, 1 cycle
//          | iteration_count, end_of_run                 |
// config   | cfg_we, cfg_index, cfg_data                 | cfg_we
//
// A non-final point is taken into the point store. A final point starts a run:
// the seeds are copied into the centroids, then each pass finds the nearest
// centroid of every point, sums the points per cluster and divides each sum
// in the serial divider. Results then leave one per cycle. busy is high for the
// whole run; the receiver cannot stall. Reset clears control state only.
module kmeans_point_clustering import kmc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  coord_t              coord_x,
	input  coord_t              coord_y,
	input  coord_t              coord_z,
	input  logic                final_point,
	input  logic                cfg_we,
	input  logic [CIDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	output logic                out_valid,
	output logic [PIDX_W-1:0]   point_index,
	output logic [2:0]          cluster_id,
	output logic [1:0]          run_status,
	output logic [7:0]          iteration_count,
	output logic                end_of_run
);
	localparam logic [3:0] S_IDLE = 4'd0, S_SEED = 4'd1, S_PRE = 4'd2,
		S_DIST = 4'd3, S_ACC = 4'd4, S_DIV = 4'd5, S_DWAIT = 4'd6,
		S_PASS = 4'd7, S_OUT = 4'd8, S_ORD = 4'd9;

	logic [3:0]        state_q;
	logic [K_W-1:0]    ncl_q;
	logic [PIDX_W-1:0] seed_q;
	logic [7:0]        maxit_q;
	logic [CNT_W-1:0]  loaded_q, n_q;
	logic [K_W-1:0]    k_q;
	logic [7:0]        cap_q, pass_q;
	logic              chg_q;
	logic [PIDX_W-1:0] pi_q;
	logic [CID_W-1:0]  cj_q, best_q;
	logic [1:0]        ax_q;
	logic [DIST_W-1:0] acc_q, bestd_q;
	logic [CID_W-1:0]  lab_rd_q;

	point_t            pmem [MAX_POINTS];
	logic [CID_W-1:0]  lmem [MAX_POINTS];
	point_t            pt_q;
	coord_t            cent_q [MAX_CLUSTERS][3];
	logic signed [SUM_W-1:0] sum_q [MAX_CLUSTERS][3];
	logic [CNT_W-1:0]  mcnt_q [MAX_CLUSTERS];

	// distance unit: one axis a cycle, difference, square, accumulate
	coord_t                   pa, ca;
	logic signed [DIFF_W-1:0] dif;
	logic [SQ_W-1:0]          sq;
	logic [DIST_W-1:0]        dsum;
	always_comb begin
		case (ax_q)
			2'd0:    pa = pt_q.x;
			2'd1:    pa = pt_q.y;
			default: pa = pt_q.z;
		endcase
		ca   = cent_q[cj_q][ax_q];
		dif  = DIFF_W'(pa) - DIFF_W'(ca);
		sq   = SQ_W'(dif * dif);
		dsum = acc_q + DIST_W'(sq);
	end

	logic [PIDX_W-1:0] rd_addr;
	logic              div_start, div_done;
	coord_t            div_q;
	div_ctl_t          dctl;
	assign dctl.start = (state_q == S_DIV);
	assign dctl.last  = (cj_q == CID_W'(k_q - 1'b1)) && (ax_q == 2'd2);
	assign div_start  = dctl.start;

	kmc_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(sum_q[cj_q][ax_q]), .divisor(mcnt_q[cj_q]),
		.done(div_done), .quotient(div_q)
	);

	assign busy = (state_q != S_IDLE);

	always_comb begin
		case (state_q)
			S_SEED:  rd_addr = PIDX_W'(seed_q + PIDX_W'(cj_q));
			default: rd_addr = pi_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (start && !busy && loaded_q < CNT_W'(MAX_POINTS))
			pmem[loaded_q[PIDX_W-1:0]] <= '{coord_x, coord_y, coord_z};
		pt_q     <= pmem[rd_addr];
		lab_rd_q <= lmem[rd_addr];
		if (state_q == S_ACC)
			lmem[pi_q] <= best_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ncl_q    <= K_W'(2);
			seed_q   <= PIDX_W'(9);
			maxit_q  <= 8'd64;
			loaded_q <= '0;
			pass_q   <= '0;
			chg_q    <= 1'b1;
			out_valid <= 1'b0;
		end else begin
			out_valid <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_NUM_CLUSTERS: ncl_q  <= K_W'(cfg_data[3:0]);
					REG_SEED_START:   seed_q <= cfg_data[PIDX_W-1:0];
					REG_MAX_ITER:     maxit_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: if (start) begin
					if (final_point) begin
						n_q <= (loaded_q < CNT_W'(MAX_POINTS)) ?
							loaded_q + 1'b1 : loaded_q;
						loaded_q <= '0;
						k_q <= (ncl_q == '0) ? K_W'(1) :
							(ncl_q > K_W'(MAX_CLUSTERS)) ? K_W'(MAX_CLUSTERS) : ncl_q;
						cap_q <= (maxit_q == '0) ? 8'd1 : maxit_q;
						cj_q  <= '0;
						state_q <= S_ORD;
					end else if (loaded_q < CNT_W'(MAX_POINTS))
						loaded_q <= loaded_q + 1'b1;
				end
				S_ORD: begin
					if ((CNT_W+1)'(seed_q) + (CNT_W+1)'(k_q) > (CNT_W+1)'(n_q)) begin
						out_valid <= 1'b1;
						point_index <= '0;
						cluster_id <= '0;
						run_status <= ST_TOO_FEW;
						iteration_count <= '0;
						end_of_run <= 1'b1;
						state_q <= S_IDLE;
					end else
						state_q <= S_SEED;
					ax_q <= 2'd0;
				end
				S_SEED: begin
					// read issued this cycle; data lands next, written below
					state_q <= S_PRE;
					ax_q <= 2'd3;
				end
				S_PRE: begin
					if (ax_q == 2'd3) begin
						cent_q[cj_q][0] <= pt_q.x;
						cent_q[cj_q][1] <= pt_q.y;
						cent_q[cj_q][2] <= pt_q.z;
						if (cj_q == CID_W'(k_q - 1'b1)) begin
							pass_q <= '0;
							chg_q  <= 1'b1;
							pi_q   <= '0;
							ax_q   <= 2'd0;
							for (int j = 0; j < MAX_CLUSTERS; j++) begin
								mcnt_q[j] <= '0;
								for (int a = 0; a < 3; a++) sum_q[j][a] <= '0;
							end
						end else begin
							cj_q <= cj_q + 1'b1;
							state_q <= S_SEED;
						end
					end else begin
						// point pi_q now in pt_q; start distances
						cj_q <= '0;
						ax_q <= 2'd0;
						acc_q <= '0;
						state_q <= S_DIST;
					end
					if (ax_q == 2'd3 && cj_q == CID_W'(k_q - 1'b1)) begin
						cj_q <= '0;
						state_q <= S_PASS;
					end
				end
				S_PASS: begin
					// wait while point pi_q is read into pt_q
					ax_q <= 2'd0;
					state_q <= S_PRE;
				end
				S_DIST: begin
					if (ax_q == 2'd2) begin
						acc_q <= '0;
						ax_q  <= 2'd0;
						if (cj_q == '0 || dsum < bestd_q) begin
							bestd_q <= dsum;
							best_q  <= cj_q;
						end
						if (cj_q == CID_W'(k_q - 1'b1))
							state_q <= S_ACC;
						else
							cj_q <= cj_q + 1'b1;
					end else begin
						acc_q <= dsum;
						ax_q  <= ax_q + 1'b1;
					end
				end
				S_ACC: begin
					if (pass_q == '0 || lab_rd_q != best_q) chg_q <= 1'b1;
					mcnt_q[best_q] <= mcnt_q[best_q] + 1'b1;
					sum_q[best_q][0] <= sum_q[best_q][0] + SUM_W'(pt_q.x);
					sum_q[best_q][1] <= sum_q[best_q][1] + SUM_W'(pt_q.y);
					sum_q[best_q][2] <= sum_q[best_q][2] + SUM_W'(pt_q.z);
					if (CNT_W'(pi_q) == n_q - 1'b1) begin
						cj_q <= '0;
						ax_q <= '0;
						state_q <= S_DIV;
					end else begin
						pi_q <= pi_q + 1'b1;
						state_q <= S_PASS;
					end
				end
				S_DIV: state_q <= S_DWAIT;
				S_DWAIT: if (div_done) begin
					cent_q[cj_q][ax_q] <= div_q;
					if (dctl.last) begin
						pass_q <= pass_q + 1'b1;
						pi_q <= '0;
						for (int j = 0; j < MAX_CLUSTERS; j++) begin
							mcnt_q[j] <= '0;
							for (int a = 0; a < 3; a++) sum_q[j][a] <= '0;
						end
						if (!chg_q || pass_q + 1'b1 >= cap_q)
							state_q <= S_OUT;
						else begin
							chg_q <= 1'b0;
							state_q <= S_PASS;
						end
					end else begin
						if (ax_q == 2'd2) begin
							ax_q <= '0;
							cj_q <= cj_q + 1'b1;
						end else
							ax_q <= ax_q + 1'b1;
						state_q <= S_DIV;
					end
				end
				S_OUT: begin
					// label of pi_q is read while the previous result leaves;
					// with a full store pi_q wraps to zero on the last result
					pi_q <= pi_q + 1'b1;
					if (pi_q != '0 || out_valid) begin
						out_valid <= 1'b1;
						point_index <= pi_q - 1'b1;
						cluster_id <= 3'(lab_rd_q);
						run_status <= chg_q ? ST_LIMIT : ST_CONVERGED;
						iteration_count <= pass_q;
						end_of_run <= ((pi_q - 1'b1) == PIDX_W'(n_q - 1'b1));
						if ((pi_q - 1'b1) == PIDX_W'(n_q - 1'b1)) state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### sim/tb_kmeans_point_clustering.sv
// ----------------------------------------------------------------------------
// tb_kmeans_point_clustering: self-checking bench for the k-means block
// Streams point sets under changing register settings, predicts the labels of
// each run and checks every result transaction against the prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_kmeans_point_clustering;
	import kmc_pkg::*;

	typedef struct {
		logic [PIDX_W-1:0] pidx;
		logic [2:0]        cid;
		logic [1:0]        status;
		logic [7:0]        passes;
		logic              eor;
	} label_t;

	class label_board;
		label_t   pending_labels[$];
		longint   pts[MAX_POINTS][3];
		int       labels[MAX_POINTS];
		longint   cents[MAX_CLUSTERS][3];
		int       held;
		logic [3:0] k_reg;
		logic [5:0] seed_reg;
		logic [7:0] cap_reg;
		int       errors;

		function new();
			held = 0;
			k_reg = 4'd2;
			seed_reg = 6'd9;
			cap_reg = 8'd64;
			errors = 0;
		endfunction

		function void write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_NUM_CLUSTERS: k_reg = data[3:0];
				REG_SEED_START:   seed_reg = data[5:0];
				REG_MAX_ITER:     cap_reg = data[7:0];
				default: ;
			endcase
		endfunction

		function void cluster_set();
			int n, k, cap, passes, best, a;
			bit changed;
			longint d, best_d, diff, sums[MAX_CLUSTERS][3], cnt[MAX_CLUSTERS];
			label_t r;
			n = held;
			held = 0;
			k = (k_reg == 0) ? 1 : ((k_reg > MAX_CLUSTERS) ? MAX_CLUSTERS : k_reg);
			cap = (cap_reg == 0) ? 1 : cap_reg;
			if (seed_reg + k > n) begin
				r.pidx = '0; r.cid = '0; r.status = ST_TOO_FEW; r.passes = '0; r.eor = 1'b1;
				pending_labels = {pending_labels, r};
				return;
			end
			for (int j = 0; j < k; j++)
				for (a = 0; a < 3; a++) cents[j][a] = pts[seed_reg + j][a];
			passes = 0;
			changed = 1'b1;
			while (changed && passes < cap) begin
				changed = (passes == 0);
				for (int j = 0; j < MAX_CLUSTERS; j++) begin
					cnt[j] = 0;
					for (a = 0; a < 3; a++) sums[j][a] = 0;
				end
				for (int i = 0; i < n; i++) begin
					best = 0;
					best_d = 0;
					for (int j = 0; j < k; j++) begin
						d = 0;
						for (a = 0; a < 3; a++) begin
							diff = pts[i][a] - cents[j][a];
							d += diff * diff;
						end
						if (j == 0 || d < best_d) begin
							best_d = d;
							best = j;
						end
					end
					if (labels[i] != best) changed = 1'b1;
					labels[i] = best;
					cnt[best]++;
					for (a = 0; a < 3; a++) sums[best][a] += pts[i][a];
				end
				// Means truncate toward zero; an empty cluster lands on the origin.
				for (int j = 0; j < k; j++)
					for (a = 0; a < 3; a++)
						cents[j][a] = sums[j][a] / ((cnt[j] == 0) ? 1 : cnt[j]);
				passes++;
			end
			for (int i = 0; i < n; i++) begin
				r.pidx = i[PIDX_W-1:0];
				r.cid = labels[i][2:0];
				r.status = changed ? ST_LIMIT : ST_CONVERGED;
				r.passes = passes[7:0];
				r.eor = (i == n - 1);
				pending_labels = {pending_labels, r};
			end
		endfunction

		function void note_point(coord_t x, coord_t y, coord_t z, logic fin);
			if (held < MAX_POINTS) begin
				pts[held][0] = x;
				pts[held][1] = y;
				pts[held][2] = z;
				held++;
			end
			if (fin) cluster_set();
		endfunction

		function void check_label(label_t got);
			label_t w;
			if (pending_labels.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: idx %0d cid %0d st %0d it %0d eor %0d",
						got.pidx, got.cid, got.status, got.passes, got.eor);
				return;
			end
			w = pending_labels.pop_front();
			if (got.pidx !== w.pidx || got.cid !== w.cid || got.status !== w.status ||
				got.passes !== w.passes || got.eor !== w.eor) begin
				errors++;
				if (errors <= 10)
					$display("mismatch idx/cid/st/it/eor: exp %0d/%0d/%0d/%0d/%0d %s",
						w.pidx, w.cid, w.status, w.passes, w.eor,
						$sformatf("got %0d/%0d/%0d/%0d/%0d",
							got.pidx, got.cid, got.status, got.passes, got.eor));
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	coord_t            coord_x = '0, coord_y = '0, coord_z = '0;
	logic              final_point = 1'b0;
	logic              cfg_we = 1'b0;
	logic [CIDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]  cfg_data = '0;
	logic              out_valid;
	logic [PIDX_W-1:0] point_index;
	logic [2:0]        cluster_id;
	logic [1:0]        run_status;
	logic [7:0]        iteration_count;
	logic              end_of_run;

	label_board board = new();
	int sent = 0;
	int burst_left = 0;

	kmeans_point_clustering u_dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		label_t r;
		if (arst_n && out_valid) begin
			r.pidx = point_index; r.cid = cluster_id; r.status = run_status;
			r.passes = iteration_count; r.eor = end_of_run;
			board.check_label(r);
		end
	end

	initial begin
		#500ms;
		$display("TEST FAILED");
		$finish;
	end

	task automatic send_point(coord_t x, coord_t y, coord_t z, logic fin);
		@(negedge clk);
		start = 1'b1;
		coord_x = x; coord_y = y; coord_z = z; final_point = fin;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		board.note_point(x, y, z, fin);
		sent++;
		// Bursts of back-to-back transactions separated by random gaps.
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			@(negedge clk);
			start = 1'b0;
			repeat ($urandom_range(0, 4)) @(negedge clk);
		end else
			burst_left--;
	endtask

	task automatic go_idle();
		if (start) begin
			@(negedge clk);
			start = 1'b0;
		end
		while (board.pending_labels.size() != 0 || busy) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we = 1'b1; cfg_index = idx; cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		board.write_reg(idx, data);
	endtask

	task automatic configure(int k, int seed, int cap);
		go_idle();
		set_reg(REG_NUM_CLUSTERS, k[7:0]);
		set_reg(REG_SEED_START, seed[7:0]);
		set_reg(REG_MAX_ITER, cap[7:0]);
	endtask

	function automatic coord_t near(coord_t c, int spread);
		int v;
		v = int'(c) + $urandom_range(0, 2 * spread) - spread;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return coord_t'(v);
	endfunction

	// One set of n points; clustered sets get groups around random centers.
	task automatic send_set(int n, bit clustered);
		coord_t cx[4], cy[4], cz[4];
		int g, spread;
		spread = $urandom_range(1, 3000);
		for (int i = 0; i < 4; i++) begin
			cx[i] = coord_t'($urandom); cy[i] = coord_t'($urandom);
			cz[i] = coord_t'($urandom);
		end
		for (int i = 0; i < n; i++) begin
			g = $urandom_range(0, 3);
			if (clustered)
				send_point(near(cx[g], spread), near(cy[g], spread), near(cz[g], spread),
					i == n - 1);
			else
				send_point(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
					i == n - 1);
		end
	endtask

	initial begin
		int n, k, seed, cap;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// Reset settings: three points are too few for a seed at index nine.
		send_set(3, 1'b0);
		// Reset settings with enough points.
		send_set(12, 1'b1);
		go_idle();
		// Extreme coordinates with seed at zero; ties and identical points.
		configure(3, 0, 255);
		send_point(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
		send_point(-16'sh8000, -16'sh8000, -16'sh8000, 1'b0);
		send_point(16'sh0000, 16'sh0000, 16'sh0000, 1'b0);
		send_point(16'sh7fff, -16'sh8000, 16'sh0001, 1'b0);
		send_point(16'sh0000, 16'sh0000, 16'sh0000, 1'b1);
		// Cluster count zero acts as one; pass cap zero acts as one.
		configure(0, 0, 0);
		send_set(4, 1'b0);
		// Cluster count above the maximum saturates; pass cap of one.
		configure(15, 1, 1);
		send_set(10, 1'b0);
		// Single point set, seed at the highest index.
		configure(1, 63, 2);
		send_point(16'sh1234, -16'sh0042, 16'sh0001, 1'b1);

		while (sent < 145) begin
			n = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 68) : $urandom_range(2, 12);
			k = $urandom_range(1, 8);
			if (k > n) k = n;
			if ($urandom_range(0, 7) == 0) begin
				k = $urandom_range(0, 15);
				seed = $urandom_range(0, 63);
			end else
				seed = $urandom_range(0, ((n > MAX_POINTS) ? MAX_POINTS : n) - k);
			cap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 255);
			if (n > 20 && cap > 8) cap = 8;
			configure(k | ($urandom_range(0, 15) << 4), seed | ($urandom_range(0, 3) << 6), cap);
			send_set(n, $urandom_range(0, 4) != 0);
		end

		go_idle();
		repeat (200) @(posedge clk);
		if (board.errors == 0 && board.pending_labels.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

### filelist.f
hw/rtl/kmc_pkg.sv
hw/rtl/kmc_divider.sv
hw/rtl/kmeans_point_clustering.sv
sim/tb_kmeans_point_clustering.sv
